>>> design/dcdt_pkg.sv
package dcdt_pkg;

    // default number of deadline cells
    localparam int SLOTS_DEFAULT = 8;

    // payload widths
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 3;
    localparam int DELAY_W = 31;
    localparam int TIME_W  = 64;
    localparam int KIND_W  = 3;
    localparam int WAKE_W  = 31;
    localparam int ACT_W   = 4;
    localparam int INTV_W  = 32;
    localparam int CFG_IDX_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TIME   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCHED  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] K_FIRED  = 3'd0;
    localparam logic [KIND_W-1:0] K_TICK   = 3'd1;
    localparam logic [KIND_W-1:0] K_SECOND = 3'd2;
    localparam logic [KIND_W-1:0] K_WAKE   = 3'd3;
    localparam logic [KIND_W-1:0] K_STATUS = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 2'd2;

    // configuration reset values
    localparam logic [ACT_W-1:0]  ACTIVE_RST = 4'd8;
    localparam logic [INTV_W-1:0] TICK_RST   = 32'd200000;
    localparam logic [INTV_W-1:0] SECOND_RST = 32'd1000000;

    // saturation limit of the wake delay
    localparam logic [WAKE_W-1:0] WAKE_MAX = {WAKE_W{1'b1}};

    // per-cell control
    typedef struct packed {
        logic shift;
        logic wr;
    } t_cell_ctrl;

    // one result beat
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] fired_slot;
        logic              status;
        logic [WAKE_W-1:0] wake_delay;
        logic              last;
    } t_result;

endpackage

>>> design/deferred_call_deadline_timer.sv
// Deadline timer array with periodic tick and per-second events. The deadlines live in a
// ring of SLOTS cells; a time item rotates the ring once around, one cell per cycle unless
// a firing cell waits for room in the output register, checking the head cell for expiry
// and folding its distance into the wake delay, then steps through the tick check, the
// second check, the tick due time and the wake delay, where a tick, second or wake beat
// waits for room in the output register under output stall. A schedule or cancel item
// waits the same way for its status beat; command code 3 gives no beat. The input stalls
// until an item is done. Results leave through a one-deep output register in order, the
// final beat of each item marked by o_last. The deadline cells clear at reset with no
// extra pass.
module deferred_call_deadline_timer #(
    parameter int SLOTS = dcdt_pkg::SLOTS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [dcdt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dcdt_pkg::INTV_W-1:0]      i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [dcdt_pkg::CMD_W-1:0]       i_command,
    input  logic [dcdt_pkg::SLOT_W-1:0]      i_slot,
    input  logic [dcdt_pkg::DELAY_W-1:0]     i_delay,
    input  logic [dcdt_pkg::TIME_W-1:0]      i_now,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [dcdt_pkg::KIND_W-1:0]      o_kind,
    output logic [dcdt_pkg::SLOT_W-1:0]      o_fired_slot,
    output logic                             o_status,
    output logic [dcdt_pkg::WAKE_W-1:0]      o_wake_delay,
    output logic                             o_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam int TW = dcdt_pkg::TIME_W;
    localparam int WW = dcdt_pkg::WAKE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_SCAN,
        S_TICK,
        S_SEC,
        S_DUE,
        S_WAKE
    } t_state;

    // control and configuration registers
    t_state                        r_state, n_state;
    logic [IDX_W-1:0]              r_idx, n_idx;
    logic [WW-1:0]                 r_acc, n_acc;
    logic [TW-1:0]                 r_last_tick, n_last_tick;
    logic [TW-1:0]                 r_last_sec, n_last_sec;
    logic [TW-1:0]                 r_due, n_due;
    logic [dcdt_pkg::ACT_W-1:0]    r_active;
    logic [dcdt_pkg::INTV_W-1:0]   r_tick_int;
    logic [dcdt_pkg::INTV_W-1:0]   r_sec_int;

    // captured input item
    logic [dcdt_pkg::CMD_W-1:0]    r_cmd;
    logic [dcdt_pkg::SLOT_W-1:0]   r_slot;
    logic [dcdt_pkg::DELAY_W-1:0]  r_delay;
    logic [TW-1:0]                 r_now;

    // cell ring
    logic [TW-1:0]                 w_cell_q [SLOTS];
    logic [SLOTS-1:0]              w_sel;
    logic [TW-1:0]                 w_feed;
    logic [TW-1:0]                 w_wr_data;
    logic                          w_shift;
    logic                          w_wr;

    // head cell evaluation
    logic [TW-1:0]                 w_head;
    logic [TW-1:0]                 w_hdiff;
    logic                          w_hborrow;
    logic                          w_active;
    logic                          w_fire;
    logic                          w_use;
    logic [WW-1:0]                 w_hsat;

    // event checks and wake delay
    logic [TW-1:0]                 w_tdiff;
    logic [TW-1:0]                 w_sdiff;
    logic                          w_tick_hit;
    logic                          w_sec_hit;
    logic [TW-1:0]                 w_wdiff;
    logic                          w_wborrow;
    logic [WW-1:0]                 w_wval;
    logic [WW-1:0]                 w_wake;
    logic                          w_slot_ok;

    // output register side
    logic                          w_load;
    logic                          w_free;
    dcdt_pkg::t_result             w_res;
    dcdt_pkg::t_result             w_out;

    assign o_in_stall = (r_state != S_IDLE);

    // slot is registered when below the saturated active count
    assign w_slot_ok = (32'(r_slot) < 32'(r_active)) && (32'(r_slot) < SLOTS);

    // head cell: compare and distance in one subtract
    assign w_head   = w_cell_q[0];
    assign {w_hborrow, w_hdiff} = {1'b0, w_head} - {1'b0, r_now};
    assign w_active = (32'(r_idx) < 32'(r_active));
    assign w_fire   = w_active && (w_head != '0) && w_hborrow;
    assign w_use    = w_active && (w_head != '0) && !w_hborrow;
    assign w_hsat   = (|w_hdiff[TW-1:WW]) ? dcdt_pkg::WAKE_MAX : w_hdiff[WW-1:0];

    // a fired deadline re-enters the ring as idle
    assign w_feed    = w_fire ? '0 : w_head;
    assign w_wr_data = (r_cmd == dcdt_pkg::CMD_SCHED) ? (r_now + TW'(r_delay)) : '0;

    // interval checks
    assign w_tdiff    = r_now - r_last_tick;
    assign w_sdiff    = r_now - r_last_sec;
    assign w_tick_hit = (w_tdiff >= TW'(r_tick_int));
    assign w_sec_hit  = (w_sdiff >= TW'(r_sec_int));

    // wake delay from the tick due time, then the cell minimum
    assign {w_wborrow, w_wdiff} = {1'b0, r_due} - {1'b0, r_now};
    assign w_wval = w_wborrow ? '0
                  : ((|w_wdiff[TW-1:WW]) ? dcdt_pkg::WAKE_MAX : w_wdiff[WW-1:0]);
    assign w_wake = (w_wval < r_acc) ? w_wval : r_acc;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_last_tick = r_last_tick;
        n_last_sec  = r_last_sec;
        n_due       = r_due;
        w_shift     = 1'b0;
        w_wr        = 1'b0;
        w_load      = 1'b0;
        w_res       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        dcdt_pkg::CMD_TIME: begin
                            n_state = S_SCAN;
                            n_idx   = '0;
                            n_acc   = dcdt_pkg::WAKE_MAX;
                        end
                        dcdt_pkg::CMD_SCHED, dcdt_pkg::CMD_CANCEL: begin
                            n_state = S_CMD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CMD: begin
                if (w_free) begin
                    w_wr         = w_slot_ok;
                    w_load       = 1'b1;
                    w_res.kind   = dcdt_pkg::K_STATUS;
                    w_res.status = !w_slot_ok;
                    w_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                // a firing cell waits for room in the output register
                if (!w_fire || w_free) begin
                    w_shift          = 1'b1;
                    w_load           = w_fire;
                    w_res.kind       = dcdt_pkg::K_FIRED;
                    w_res.fired_slot = dcdt_pkg::SLOT_W'(r_idx);
                    if (w_use && (w_hsat < r_acc)) begin
                        n_acc = w_hsat;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_TICK;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_TICK: begin
                if (!w_tick_hit) begin
                    n_state = S_SEC;
                end else if (w_free) begin
                    w_load      = 1'b1;
                    w_res.kind  = dcdt_pkg::K_TICK;
                    n_last_tick = r_now;
                    n_state     = S_SEC;
                end
            end
            S_SEC: begin
                if (!w_sec_hit) begin
                    n_state = S_DUE;
                end else if (w_free) begin
                    w_load     = 1'b1;
                    w_res.kind = dcdt_pkg::K_SECOND;
                    n_last_sec = r_now;
                    n_state    = S_DUE;
                end
            end
            S_DUE: begin
                n_due   = r_last_tick + TW'(r_tick_int);
                n_state = S_WAKE;
            end
            S_WAKE: begin
                if (w_free) begin
                    w_load           = 1'b1;
                    w_res.kind       = dcdt_pkg::K_WAKE;
                    w_res.wake_delay = w_wake;
                    w_res.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, timing registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_acc       <= dcdt_pkg::WAKE_MAX;
            r_last_tick <= '0 - TW'(dcdt_pkg::TICK_RST);
            r_last_sec  <= '0 - TW'(dcdt_pkg::SECOND_RST);
            r_due       <= '0;
            r_active    <= dcdt_pkg::ACTIVE_RST;
            r_tick_int  <= dcdt_pkg::TICK_RST;
            r_sec_int   <= dcdt_pkg::SECOND_RST;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_acc       <= n_acc;
            r_last_tick <= n_last_tick;
            r_last_sec  <= n_last_sec;
            r_due       <= n_due;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dcdt_pkg::CFG_ACTIVE: r_active   <= i_cfg_data[dcdt_pkg::ACT_W-1:0];
                    dcdt_pkg::CFG_TICK:   r_tick_int <= i_cfg_data;
                    dcdt_pkg::CFG_SECOND: r_sec_int  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd   <= i_command;
            r_slot  <= i_slot;
            r_delay <= i_delay;
            r_now   <= i_now;
        end
    end

    // ring of deadline cells, cell 0 is the head
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        dcdt_pkg::t_cell_ctrl w_ctrl;
        logic [TW-1:0]        w_in;

        assign w_sel[g]     = (32'(r_slot) == g);
        assign w_ctrl.shift = w_shift;
        assign w_ctrl.wr    = w_wr && w_sel[g];
        if (g == SLOTS - 1) begin : g_tail
            assign w_in = w_feed;
        end else begin : g_mid
            assign w_in = w_cell_q[g + 1];
        end

        dcdt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_shift_data (w_in),
            .i_wr_data    (w_wr_data),
            .o_deadline   (w_cell_q[g])
        );
    end

    // result output register
    dcdt_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_free  (w_free),
        .o_res   (w_out)
    );

    assign o_kind       = w_out.kind;
    assign o_fired_slot = w_out.fired_slot;
    assign o_status     = w_out.status;
    assign o_wake_delay = w_out.wake_delay;
    assign o_last       = w_out.last;

`ifndef SYNTHESIS
    // the scan ends only after a full turn of the ring
    a_scan_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_TICK) |-> (r_idx == LAST_IDX))
        else $error("scan left before a full ring turn");

    // the wake beat closes a time item
    a_wake_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAKE && w_free) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after wake beat");

    // only status and wake beats end an item
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |->
            (o_kind == dcdt_pkg::K_WAKE || o_kind == dcdt_pkg::K_STATUS))
        else $error("last flag on a mid-item beat");

    // no beat is produced while waiting for an item
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_load)
        else $error("result loaded while idle");

    // a beat is loaded only when the output register has room
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_free)
        else $error("result overwrote a stalled beat");
`endif

endmodule

>>> design/dcdt_cell.sv
module dcdt_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dcdt_pkg::t_cell_ctrl           i_ctrl,
    input  logic [dcdt_pkg::TIME_W-1:0]    i_shift_data,
    input  logic [dcdt_pkg::TIME_W-1:0]    i_wr_data,
    output logic [dcdt_pkg::TIME_W-1:0]    o_deadline
);

    logic [dcdt_pkg::TIME_W-1:0] r_deadline;
    logic [dcdt_pkg::TIME_W-1:0] n_deadline;

    // rotate along the ring, or take a direct write
    always_comb begin
        n_deadline = r_deadline;
        if (i_ctrl.shift) begin
            n_deadline = i_shift_data;
        end else if (i_ctrl.wr) begin
            n_deadline = i_wr_data;
        end
    end

    // deadline storage, zero means idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
        end else begin
            r_deadline <= n_deadline;
        end
    end

    assign o_deadline = r_deadline;

endmodule

>>> design/dcdt_outreg.sv
module dcdt_outreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dcdt_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_free,
    output dcdt_pkg::t_result o_res
);

    logic              r_valid;
    dcdt_pkg::t_result r_res;

    // register is free when empty or its beat leaves this cycle
    assign o_free = !r_valid || !i_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> sim/deferred_call_deadline_timer_tb.sv
`timescale 1ns / 1ps

module deferred_call_deadline_timer_tb;

    // unused command code, ignored by the block
    localparam logic [dcdt_pkg::CMD_W-1:0] CMD_IGNORED = 2'd3;
    localparam logic [dcdt_pkg::DELAY_W-1:0] DELAY_MAX = {dcdt_pkg::DELAY_W{1'b1}};
    localparam logic [dcdt_pkg::INTV_W-1:0] INTV_MAX = {dcdt_pkg::INTV_W{1'b1}};
    // a time item rotates the ring once, then runs the tick, second, due and wake steps
    localparam int ITEM_LATENCY = dcdt_pkg::SLOTS_DEFAULT + 5;
    localparam int SETTLE_CYCLES = 2 * ITEM_LATENCY;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 5000;
    localparam int REPORT_MAX = 10;

    // predicts the result beats of the deadline table and checks them in order
    class deadline_scoreboard;
        logic [dcdt_pkg::ACT_W-1:0]  active_slots;
        logic [dcdt_pkg::INTV_W-1:0] tick_interval;
        logic [dcdt_pkg::INTV_W-1:0] second_interval;
        logic [dcdt_pkg::TIME_W-1:0] deadlines [dcdt_pkg::SLOTS_DEFAULT];
        logic [dcdt_pkg::TIME_W-1:0] last_tick_time;
        logic [dcdt_pkg::TIME_W-1:0] last_second_time;
        dcdt_pkg::t_result           expected_beats [$];
        int                          mismatches;

        function new();
            active_slots = dcdt_pkg::ACTIVE_RST;
            tick_interval = dcdt_pkg::TICK_RST;
            second_interval = dcdt_pkg::SECOND_RST;
            foreach (deadlines[i]) deadlines[i] = '0;
            last_tick_time = 64'd0 - {32'd0, dcdt_pkg::TICK_RST};
            last_second_time = 64'd0 - {32'd0, dcdt_pkg::SECOND_RST};
            mismatches = 0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void write_reg(logic [dcdt_pkg::CFG_IDX_W-1:0] idx,
                                logic [dcdt_pkg::INTV_W-1:0] data);
            case (idx)
                dcdt_pkg::CFG_ACTIVE: active_slots = data[dcdt_pkg::ACT_W-1:0];
                dcdt_pkg::CFG_TICK:   tick_interval = data;
                dcdt_pkg::CFG_SECOND: second_interval = data;
                default: ;
            endcase
        endfunction

        function dcdt_pkg::t_result make_beat(logic [dcdt_pkg::KIND_W-1:0] kind,
                                              logic [dcdt_pkg::SLOT_W-1:0] slot,
                                              logic st, logic [dcdt_pkg::WAKE_W-1:0] wake);
            dcdt_pkg::t_result b;
            b.kind = kind;
            b.fired_slot = slot;
            b.status = st;
            b.wake_delay = wake;
            b.last = 1'b0;
            return b;
        endfunction

        // update the table for one accepted command and queue its beats
        function void note_command(logic [dcdt_pkg::CMD_W-1:0] cmd,
                                   logic [dcdt_pkg::SLOT_W-1:0] slot,
                                   logic [dcdt_pkg::DELAY_W-1:0] delay,
                                   logic [dcdt_pkg::TIME_W-1:0] now);
            int unsigned act;
            dcdt_pkg::t_result beats [$];
            logic st;
            logic [dcdt_pkg::TIME_W-1:0] due;
            logic [dcdt_pkg::TIME_W-1:0] wake;
            act = (active_slots > dcdt_pkg::SLOTS_DEFAULT) ? dcdt_pkg::SLOTS_DEFAULT
                                                           : active_slots;
            if (cmd == CMD_IGNORED) return;
            if (cmd == dcdt_pkg::CMD_SCHED || cmd == dcdt_pkg::CMD_CANCEL) begin
                st = 1'b1;
                if (slot < act) begin
                    deadlines[slot] = (cmd == dcdt_pkg::CMD_SCHED) ? now + {33'd0, delay} : '0;
                    st = 1'b0;
                end
                beats.push_back(make_beat(dcdt_pkg::K_STATUS, '0, st, '0));
            end else begin
                // expired slots in ascending order
                for (int i = 0; i < act; i++) begin
                    if (deadlines[i] != '0 && deadlines[i] < now) begin
                        deadlines[i] = '0;
                        beats.push_back(make_beat(dcdt_pkg::K_FIRED,
                                                  dcdt_pkg::SLOT_W'(i), 1'b0, '0));
                    end
                end
                // periodic events
                if (now - last_tick_time >= {32'd0, tick_interval}) begin
                    last_tick_time = now;
                    beats.push_back(make_beat(dcdt_pkg::K_TICK, '0, 1'b0, '0));
                end
                if (now - last_second_time >= {32'd0, second_interval}) begin
                    last_second_time = now;
                    beats.push_back(make_beat(dcdt_pkg::K_SECOND, '0, 1'b0, '0));
                end
                // wake delay: next tick, shortened by pending deadlines
                due = last_tick_time + {32'd0, tick_interval};
                wake = (due > now) ? due - now : '0;
                if (wake > {33'd0, dcdt_pkg::WAKE_MAX}) wake = {33'd0, dcdt_pkg::WAKE_MAX};
                for (int i = 0; i < act && wake != '0; i++) begin
                    if (deadlines[i] == '0) continue;
                    if (deadlines[i] < now) wake = '0;
                    else if (deadlines[i] - now < wake) wake = deadlines[i] - now;
                end
                beats.push_back(make_beat(dcdt_pkg::K_WAKE, '0, 1'b0,
                                          wake[dcdt_pkg::WAKE_W-1:0]));
            end
            beats[beats.size()-1].last = 1'b1;
            foreach (beats[i]) expected_beats.push_back(beats[i]);
        endfunction

        function void check_beat(logic [dcdt_pkg::KIND_W-1:0] kind,
                                 logic [dcdt_pkg::SLOT_W-1:0] slot,
                                 logic st, logic [dcdt_pkg::WAKE_W-1:0] wake, logic last);
            dcdt_pkg::t_result e;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected beat: kind=%0d slot=%0d status=%0d wake=%0d last=%0d",
                             kind, slot, st, wake, last);
                return;
            end
            e = expected_beats.pop_front();
            if (e.kind !== kind || e.fired_slot !== slot || e.status !== st ||
                e.wake_delay !== wake || e.last !== last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("beat mismatch at %0t ns", $time);
                    $display("  expected kind=%0d slot=%0d status=%0d wake=%0d last=%0d",
                             e.kind, e.fired_slot, e.status, e.wake_delay, e.last);
                    $display("  actual   kind=%0d slot=%0d status=%0d wake=%0d last=%0d",
                             kind, slot, st, wake, last);
                end
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [dcdt_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [dcdt_pkg::INTV_W-1:0]    i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [dcdt_pkg::CMD_W-1:0]     i_command;
    logic [dcdt_pkg::SLOT_W-1:0]    i_slot;
    logic [dcdt_pkg::DELAY_W-1:0]   i_delay;
    logic [dcdt_pkg::TIME_W-1:0]    i_now;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [dcdt_pkg::KIND_W-1:0]    o_kind;
    logic [dcdt_pkg::SLOT_W-1:0]    o_fired_slot;
    logic                           o_status;
    logic [dcdt_pkg::WAKE_W-1:0]    o_wake_delay;
    logic                           o_last;

    deadline_scoreboard             sb;
    bit                             hold_go;
    logic [dcdt_pkg::TIME_W-1:0]    wall_now;
    int                             quiet_cycles;

    deferred_call_deadline_timer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_slot       (i_slot),
        .i_delay      (i_delay),
        .i_now        (i_now),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_fired_slot (o_fired_slot),
        .o_status     (o_status),
        .o_wake_delay (o_wake_delay),
        .o_last       (o_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        int mode_left;
        int phase_cnt;
        mode = 0;
        mode_left = 0;
        phase_cnt = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_go = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                phase_cnt++;
                case (mode)
                    0: i_out_stall = 1'b0;
                    1: i_out_stall = ($urandom_range(0, 3) == 0);
                    2: i_out_stall = ($urandom_range(0, 3) != 0);
                    default: i_out_stall = (phase_cnt % 5 < 2);
                endcase
            end
        end
    end

    // result beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat(o_kind, o_fired_slot, o_status, o_wake_delay, o_last);
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("no beat moved for %0d cycles", QUIET_LIMIT);
            $display("** deferred_call_deadline_timer: FAILED **");
            $finish;
        end
    end

    // offer one command beat and hold it until accepted; called at a falling edge
    task automatic send_item(input logic [dcdt_pkg::CMD_W-1:0] cmd,
                             input logic [dcdt_pkg::SLOT_W-1:0] slot,
                             input logic [dcdt_pkg::DELAY_W-1:0] delay,
                             input logic [dcdt_pkg::TIME_W-1:0] now);
        i_command = cmd;
        i_slot = slot;
        i_delay = delay;
        i_now = now;
        i_in_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        sb.note_command(cmd, slot, delay, now);
        @(negedge i_clk);
    endtask

    task automatic idle_for(input int cycles);
        i_in_valid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // wait until every expected beat has arrived
    task automatic settle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [dcdt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dcdt_pkg::INTV_W-1:0] data);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_we = 1'b1;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // mostly schedule, cancel and monotonic time beats, some noise
    task automatic random_traffic(input int count, input bit steady);
        int burst_left;
        int sel;
        logic [dcdt_pkg::CMD_W-1:0] cmd;
        logic [dcdt_pkg::SLOT_W-1:0] slot;
        logic [dcdt_pkg::DELAY_W-1:0] delay;
        logic [dcdt_pkg::TIME_W-1:0] now;
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < count; n++) begin
            if (!steady && burst_left == 0) begin
                idle_for($urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end
            sel = $urandom_range(0, 99);
            slot = dcdt_pkg::SLOT_W'($urandom_range(0, 7));
            delay = dcdt_pkg::DELAY_W'($urandom);
            now = wall_now;
            if (sel < 35) begin
                cmd = dcdt_pkg::CMD_SCHED;
                if ($urandom_range(0, 9) != 0) delay = dcdt_pkg::DELAY_W'($urandom_range(0, 3000));
            end else if (sel < 50) begin
                cmd = dcdt_pkg::CMD_CANCEL;
            end else if (sel < 88) begin
                cmd = dcdt_pkg::CMD_TIME;
                wall_now = wall_now + 64'($urandom_range(0, 1200));
                now = wall_now;
            end else if (sel < 93) begin
                cmd = CMD_IGNORED;
                now = {$urandom, $urandom};
            end else begin
                cmd = dcdt_pkg::CMD_W'($urandom_range(0, 2));
                now = {$urandom, $urandom};
            end
            send_item(cmd, slot, delay, now);
            burst_left--;
        end
    endtask

    initial begin
        logic [dcdt_pkg::ACT_W-1:0] act;
        logic [dcdt_pkg::INTV_W-1:0] tick_iv;
        logic [dcdt_pkg::INTV_W-1:0] sec_iv;
        sb = new();
        hold_go = 1'b0;
        wall_now = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = dcdt_pkg::CFG_ACTIVE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = dcdt_pkg::CMD_TIME;
        i_slot = '0;
        i_delay = '0;
        i_now = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: tick and second both due at time zero
        send_item(dcdt_pkg::CMD_TIME, 3'd0, '0, 64'd0);
        send_item(dcdt_pkg::CMD_SCHED, 3'd0, '0, 64'd100);
        // deadline equal to now does not fire yet
        send_item(dcdt_pkg::CMD_TIME, 3'd5, DELAY_MAX, 64'd100);
        send_item(dcdt_pkg::CMD_TIME, 3'd0, '0, 64'd101);
        send_item(dcdt_pkg::CMD_SCHED, 3'd7, DELAY_MAX, 64'd200);
        send_item(dcdt_pkg::CMD_SCHED, 3'd3, 31'd50, 64'd200);
        send_item(dcdt_pkg::CMD_CANCEL, 3'd3, '0, 64'd0);
        // deadline sum wraps to zero, slot stays idle
        send_item(dcdt_pkg::CMD_SCHED, 3'd2, 31'd5, ~64'd4);
        send_item(CMD_IGNORED, 3'd7, DELAY_MAX, ~64'd0);
        send_item(dcdt_pkg::CMD_SCHED, 3'd1, 31'd10, ~64'd15);
        send_item(dcdt_pkg::CMD_TIME, 3'd0, '0, 64'd300);
        send_item(dcdt_pkg::CMD_TIME, 3'd0, '0, ~64'd0);
        send_item(dcdt_pkg::CMD_SCHED, 3'd4, 31'd1000, 64'd1000);
        send_item(dcdt_pkg::CMD_SCHED, 3'd6, 31'd3, 64'd1000);
        send_item(dcdt_pkg::CMD_TIME, 3'd0, '0, 64'd2000);

        // one slot registered, zero intervals fire on every time beat
        settle();
        idle_for(SETTLE_CYCLES);
        write_cfg(dcdt_pkg::CFG_ACTIVE, 32'd1);
        write_cfg(dcdt_pkg::CFG_TICK, 32'd0);
        write_cfg(dcdt_pkg::CFG_SECOND, 32'd0);
        send_item(dcdt_pkg::CMD_SCHED, 3'd5, 31'd7, 64'd10);
        send_item(dcdt_pkg::CMD_CANCEL, 3'd1, '0, 64'd10);
        send_item(dcdt_pkg::CMD_SCHED, 3'd0, 31'd20, 64'd10);
        send_item(dcdt_pkg::CMD_TIME, 3'd0, '0, 64'd10);
        send_item(dcdt_pkg::CMD_TIME, 3'd0, '0, 64'd40);

        // active count above the table size, widest intervals
        settle();
        idle_for(SETTLE_CYCLES);
        write_cfg(dcdt_pkg::CFG_ACTIVE, 32'd15);
        write_cfg(dcdt_pkg::CFG_TICK, INTV_MAX);
        write_cfg(dcdt_pkg::CFG_SECOND, INTV_MAX);
        send_item(dcdt_pkg::CMD_SCHED, 3'd7, 31'd900, 64'd5000);
        send_item(dcdt_pkg::CMD_TIME, 3'd0, '0, 64'd5000);
        send_item(dcdt_pkg::CMD_TIME, 3'd0, '0, 64'h1_0000_4000);
        send_item(dcdt_pkg::CMD_CANCEL, 3'd7, '0, 64'd0);

        // random phases, each with its own settings
        for (int p = 0; p < 6; p++) begin
            settle();
            idle_for(SETTLE_CYCLES);
            act = (p == 0) ? 4'd0 : ($urandom_range(0, 1) ? 4'd8 : 4'($urandom_range(0, 15)));
            case ($urandom_range(0, 3))
                0, 1: tick_iv = $urandom_range(1, 3000);
                2:    tick_iv = $urandom;
                default: tick_iv = (p % 2) ? INTV_MAX : 32'd0;
            endcase
            case ($urandom_range(0, 3))
                0, 1: sec_iv = $urandom_range(2000, 20000);
                2:    sec_iv = $urandom;
                default: sec_iv = (p % 2) ? 32'd0 : INTV_MAX;
            endcase
            write_cfg(dcdt_pkg::CFG_ACTIVE, {28'd0, act});
            write_cfg(dcdt_pkg::CFG_TICK, tick_iv);
            write_cfg(dcdt_pkg::CFG_SECOND, sec_iv);
            wall_now = (p % 2) ? {$urandom, $urandom} : 64'($urandom_range(0, 100000));
            // time runs across the 64-bit wrap
            if (p == 3) wall_now = 64'd0 - 64'd20000;
            // receiver holds off while the sender keeps offering beats
            if (p == 2) begin
                hold_go = 1'b1;
                random_traffic(24, 1'b1);
            end
            random_traffic(35, 1'b0);
            settle();
            random_traffic(35, 1'b0);
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0d expected beats never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** deferred_call_deadline_timer: PASSED **");
        end else begin
            $display("** deferred_call_deadline_timer: FAILED **");
        end
        $finish;
    end

endmodule
